// ===== hw/rtl/dcms_pkg.sv =====
// shared types and constants of the dc motor move sequencer
package dcms_pkg;

    // sequencer phases, encoded as they appear in the result word
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAITON = 3'd1,
        PH_MOVETO = 3'd2,
        PH_HOME   = 3'd3,
        PH_MOVING = 3'd4,
        PH_END    = 3'd5
    } phase_t;

    // request kinds carried on the input word
    typedef enum logic [1:0] {
        RQ_NONE    = 2'd0,
        RQ_MOVE    = 2'd1,
        RQ_HOME    = 2'd2,
        RQ_POWERUP = 2'd3
    } req_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RUN_WAIT     = 2'd0,
        CFG_POWERUP_WAIT = 2'd1,
        CFG_WAKE_WAIT    = 2'd2,
        CFG_HOME_TARGET  = 2'd3
    } cfg_idx_t;

    // position classes
    localparam logic [1:0] POS_END_B  = 2'd0;
    localparam logic [1:0] POS_TRAVEL = 2'd1;
    localparam logic [1:0] POS_END_A  = 2'd2;

    localparam int          WAIT_WIDTH_DEF    = 8;
    localparam int          CFG_WIDTH         = 8;
    localparam int          TGT_WIDTH         = 4;
    localparam int          ADDR_WIDTH        = 4;
    localparam int          DATA_WIDTH        = 32;
    localparam logic [7:0]  RUN_WAIT_RST      = 8'd31;
    localparam logic [7:0]  POWERUP_WAIT_RST  = 8'd10;
    localparam logic [7:0]  WAKE_WAIT_RST     = 8'd5;
    localparam logic [3:0]  HOME_TARGET_RST   = 4'h1;

endpackage

// ===== hw/rtl/dc_motor_move_sequencer_core.sv =====
// dc motor move sequencer: tick-driven move control with apb register port
// result word: registered from each accepted input word
// throughput: one word per cycle while the result word is taken; the single state update sits
// between the input handshake and the result register, which frees itself when taken
// reset: synchronous active-low aresetn clears phase, request, counters,
// drive lines and power, and restores the register defaults
module dc_motor_move_sequencer_core
    import dcms_pkg::*;
#(
    parameter int WAIT_WIDTH = WAIT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // target[3:0], sense_a[4], sense_b[5], zero pad
    input  logic [1:0]            s_tuser,   // req_type[1:0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // drive_fwd[0], drive_rev[1], motor_enable[2],
                                             // driver_power[3], converter_off[4], hv_off[5],
                                             // phase[8:6], position[10:9], zero pad
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    // configuration registers
    logic [CFG_WIDTH-1:0]  run_wait_reg;
    logic [CFG_WIDTH-1:0]  powerup_wait_reg;
    logic [CFG_WIDTH-1:0]  wake_wait_reg;
    logic [TGT_WIDTH-1:0]  home_target_reg;

    // sequencer state
    phase_t                phase_reg,   phase_next;
    req_t                  pend_reg,    pend_next;
    logic [WAIT_WIDTH-1:0] wait_reg,    wait_next;
    logic [1:0]            pos_reg,     pos_next;
    logic [TGT_WIDTH-1:0]  target_reg,  target_next;
    logic                  fwd_reg,     fwd_next;
    logic                  rev_reg,     rev_next;
    logic                  enable_reg,  enable_next;
    logic                  power_reg,   power_next;
    logic                  pulse_next;

    // result register
    logic                  m_valid_reg;
    logic [15:0]           m_data_reg;

    logic                  in_accept;
    logic                  cfg_write;
    cfg_idx_t              cfg_idx;
    req_t                  req_in;
    logic [TGT_WIDTH-1:0]  tgt_in;
    logic                  sense_a;
    logic                  sense_b;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = cfg_idx_t'(paddr[3:2]);

    // the result register frees itself in the cycle it is taken
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign req_in  = req_t'(s_tuser);
    assign tgt_in  = s_tdata[3:0];
    assign sense_a = s_tdata[4];
    assign sense_b = s_tdata[5];

    // register read back
    always_comb begin
        case (cfg_idx)
            CFG_RUN_WAIT:     prdata = DATA_WIDTH'(run_wait_reg);
            CFG_POWERUP_WAIT: prdata = DATA_WIDTH'(powerup_wait_reg);
            CFG_WAKE_WAIT:    prdata = DATA_WIDTH'(wake_wait_reg);
            CFG_HOME_TARGET:  prdata = DATA_WIDTH'(home_target_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_wait_reg     <= RUN_WAIT_RST;
            powerup_wait_reg <= POWERUP_WAIT_RST;
            wake_wait_reg    <= WAKE_WAIT_RST;
            home_target_reg  <= HOME_TARGET_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                CFG_RUN_WAIT:     run_wait_reg     <= pwdata[CFG_WIDTH-1:0];
                CFG_POWERUP_WAIT: powerup_wait_reg <= pwdata[CFG_WIDTH-1:0];
                CFG_WAKE_WAIT:    wake_wait_reg    <= pwdata[CFG_WIDTH-1:0];
                CFG_HOME_TARGET:  home_target_reg  <= pwdata[TGT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // one tick of the sequencer
    always_comb begin
        // a new request overwrites the pending one before the tick is processed
        pend_next   = (req_in != RQ_NONE) ? req_in : pend_reg;
        target_next = (req_in == RQ_MOVE) ? tgt_in : target_reg;
        phase_next  = phase_reg;
        wait_next   = wait_reg;
        pos_next    = pos_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        enable_next = enable_reg;
        power_next  = power_reg;
        pulse_next  = 1'b0;

        case (phase_reg)
            PH_IDLE: begin
                if (pend_next == RQ_NONE) begin
                    // leftover wait ticks keep the driver powered
                    if (wait_reg != '0) begin
                        wait_next  = wait_reg - 1'b1;
                        power_next = 1'b1;
                    end else begin
                        power_next = 1'b0;
                    end
                end else begin
                    wait_next  = (pend_next == RQ_POWERUP) ?
                                 WAIT_WIDTH'(powerup_wait_reg) :
                                 WAIT_WIDTH'(wake_wait_reg);
                    power_next = 1'b1;
                    phase_next = PH_WAITON;
                end
            end
            PH_WAITON: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else begin
                    case (pend_next)
                        RQ_MOVE:  phase_next = PH_MOVETO;
                        RQ_NONE:  phase_next = PH_IDLE;
                        default:  phase_next = PH_HOME;
                    endcase
                    pend_next = RQ_NONE;
                end
            end
            PH_MOVETO, PH_HOME: begin
                if (phase_reg == PH_HOME) begin
                    target_next = home_target_reg;
                end
                fwd_next    = target_next[0];
                rev_next    = !target_next[0];
                enable_next = 1'b1;
                wait_next   = WAIT_WIDTH'(run_wait_reg);
                phase_next  = PH_MOVING;
            end
            PH_MOVING: begin
                // both pins high keeps the last class
                if (!sense_a && sense_b) begin
                    pos_next = POS_END_B;
                end else if (!sense_a && !sense_b) begin
                    pos_next = POS_TRAVEL;
                end else if (sense_a && !sense_b) begin
                    pos_next = POS_END_A;
                end
                if (pos_next == POS_TRAVEL && wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else begin
                    phase_next = PH_END;
                    fwd_next   = 1'b0;
                    rev_next   = 1'b0;
                    pulse_next = 1'b1;
                end
            end
            PH_END: begin
                enable_next = 1'b0;
                phase_next  = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pend_reg   <= RQ_NONE;
            wait_reg   <= '0;
            pos_reg    <= POS_END_B;
            target_reg <= '0;
            fwd_reg    <= 1'b0;
            rev_reg    <= 1'b0;
            enable_reg <= 1'b0;
            power_reg  <= 1'b0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            wait_reg   <= wait_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
            enable_reg <= enable_next;
            power_reg  <= power_next;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {5'b0, pos_next, phase_next, pulse_next, pulse_next,
                           power_next, enable_next, rev_next, fwd_next};
        end
    end

    // both direction lines are never driven together
    assert property (@(posedge aclk) disable iff (!aresetn) !(fwd_reg && rev_reg))
        else $error("both direction lines high");

    // the end phase has already released the direction lines
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_END) |-> (!fwd_reg && !rev_reg))
        else $error("direction line still driven in end phase");

    // the bridge stays enabled throughout motion
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_MOVING) |-> enable_reg)
        else $error("moving without bridge enable");

    // an accepted word always yields a pending result
    assert property (@(posedge aclk) disable iff (!aresetn) in_accept |=> m_valid_reg)
        else $error("accepted word produced no result");

    // a stop pulse in the result word comes only with the end phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[4]) |-> (m_data_reg[8:6] == PH_END))
        else $error("stop pulse outside end phase");

endmodule
